// ----- hdl/sbsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsu_pkg
// Shared widths, register indexes and divider control types of the send ring
// sizing unit.
// ----------------------------------------------------------------------------
package sbsu_pkg;

   localparam int HOP_W   = 16;
   localparam int HIST_W  = 16;
   localparam int WIDE_W  = 32;
   localparam int LEFT_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_CNT_W  = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_NUMERATOR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DENOMINATOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLEXIBLE    = 2'd2;

   typedef struct packed {
      logic              start;
      logic [WIDE_W-1:0] dividend;
      logic [HOP_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [WIDE_W-1:0] quotient;
      logic [HOP_W-1:0]  remainder;
   } div_rsp_type;

endpackage

// ----- hdl/sbsu_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsu_req_if
// Request channel: one stream's hop size and history length per item.
// ----------------------------------------------------------------------------
interface sbsu_req_if;
   logic                        valid;
   logic                        ready;
   logic [sbsu_pkg::HOP_W-1:0]  hop_size;
   logic [sbsu_pkg::HIST_W-1:0] history_length;

   modport source (output valid, output hop_size, output history_length, input ready);
   modport sink (input valid, input hop_size, input history_length, output ready);
endinterface

// ----- hdl/sbsu_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsu_rsp_if
// Response channel: ring size, block and leftover per item.
// ----------------------------------------------------------------------------
interface sbsu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sbsu_pkg::WIDE_W-1:0] ring_size;
   logic [sbsu_pkg::WIDE_W-1:0] block_samples;
   logic [sbsu_pkg::LEFT_W-1:0] leftover_samples;

   modport source (output valid, output ring_size, output block_samples,
                   output leftover_samples, input ready);
   modport sink (input valid, input ring_size, input block_samples,
                 input leftover_samples, output ready);
endinterface

// ----- hdl/sbsu_csr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsu_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sbsu_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sbsu_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [sbsu_pkg::CSR_DATA_W-1:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

// ----- hdl/sbsu_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsu_div
// Shared restoring divider, one quotient bit per cycle: 32-bit dividend by a
// nonzero 16-bit divisor, quotient and remainder shown with a done pulse.
// ----------------------------------------------------------------------------
module sbsu_div (
   input  logic                  clock,
   input  logic                  reset,
   input  sbsu_pkg::div_req_type div_req,
   output sbsu_pkg::div_rsp_type div_rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [sbsu_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [sbsu_pkg::WIDE_W-1:0]    work_ff, work_in;
   logic [sbsu_pkg::HOP_W-1:0]     part_ff, part_in;
   logic [sbsu_pkg::HOP_W-1:0]     dvs_ff, dvs_in;
   logic [sbsu_pkg::HOP_W:0]       shifted;
   logic [sbsu_pkg::HOP_W:0]       diff;
   logic                           fits;

   assign shifted = {part_ff, work_ff[sbsu_pkg::WIDE_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      part_in = part_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         work_in = div_req.dividend;
         part_in = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[sbsu_pkg::WIDE_W-2:0], fits};
         part_in = fits ? diff[sbsu_pkg::HOP_W-1:0] : shifted[sbsu_pkg::HOP_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      part_ff <= part_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = work_ff;
   assign div_rsp.remainder = part_ff;

endmodule

// ----- hdl/send_buffer_size_unit.sv -----
`timescale 1ns / 1ps
// sequence: accept, multiply p*hop, divide by q on the divider, then for an exact
//   fixed block one Euclid modulo per step to a zero remainder; a zero hop skips the divider
// throughput: one item at a time, the next accepted as soon as a result is
//   posted; the bit-serial divider is shared by the block division and every Euclid
//   modulo; a waiting result holds the following item at its final step
// reset: synchronous, active high; registers return to p = 1, q = 1, fixed blocks
// ----------------------------------------------------------------------------
// send_buffer_size_unit
// Sizes a stream's send ring: block = ceil(p*hop/q), leftover from gcd or
// hop - 1, ring = block + leftover + history; a zero hop gives all zeros.
// ----------------------------------------------------------------------------
module send_buffer_size_unit (
   input  logic          clock,
   input  logic          reset,
   sbsu_req_if.sink      req_chan,
   sbsu_rsp_if.source    rsp_chan,
   sbsu_csr_if.sink      csr_chan
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL    = 3'd1;
   localparam logic [2:0] S_DSTART = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_EUC    = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [sbsu_pkg::HOP_W-1:0]    num_ff, num_in;
   logic [sbsu_pkg::HOP_W-1:0]    den_ff, den_in;
   logic                          flex_ff, flex_in;
   logic [sbsu_pkg::HOP_W-1:0]    hop_ff, hop_in;
   logic [sbsu_pkg::HIST_W-1:0]   hist_ff, hist_in;
   logic [sbsu_pkg::WIDE_W-1:0]   prod_ff, prod_in;
   logic [sbsu_pkg::WIDE_W-1:0]   block_ff, block_in;
   logic [sbsu_pkg::LEFT_W-1:0]   left_ff, left_in;
   logic [sbsu_pkg::HOP_W-1:0]    y_ff, y_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sbsu_pkg::WIDE_W-1:0]   rsp_ring_ff, rsp_ring_in;
   logic [sbsu_pkg::WIDE_W-1:0]   rsp_block_ff, rsp_block_in;
   logic [sbsu_pkg::LEFT_W-1:0]   rsp_left_ff, rsp_left_in;
   logic [sbsu_pkg::HOP_W-1:0]    q_eff;
   logic                          rem_zero;
   logic [sbsu_pkg::WIDE_W-1:0]   block_ceil;
   sbsu_pkg::div_req_type         div_req;
   sbsu_pkg::div_rsp_type         div_rsp;

   sbsu_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign q_eff      = (den_ff == '0) ? sbsu_pkg::HOP_W'(1) : den_ff;
   assign rem_zero   = (div_rsp.remainder == '0);
   assign block_ceil = div_rsp.quotient + sbsu_pkg::WIDE_W'(!rem_zero);

   // register writes
   assign csr_chan.ready = 1'b1;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      flex_in = flex_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            sbsu_pkg::CSR_NUMERATOR:   num_in  = csr_chan.write_data;
            sbsu_pkg::CSR_DENOMINATOR: den_in  = csr_chan.write_data;
            sbsu_pkg::CSR_FLEXIBLE:    flex_in = csr_chan.write_data[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      hop_in       = hop_ff;
      hist_in      = hist_ff;
      prod_in      = prod_ff;
      block_in     = block_ff;
      left_in      = left_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ring_in  = rsp_ring_ff;
      rsp_block_in = rsp_block_ff;
      rsp_left_in  = rsp_left_ff;
      div_req      = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               hop_in   = req_chan.hop_size;
               hist_in  = req_chan.history_length;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = sbsu_pkg::WIDE_W'(num_ff) * sbsu_pkg::WIDE_W'(hop_ff);
            if (hop_ff == '0) begin
               block_in = '0;
               left_in  = '0;
               hist_in  = '0;
               state_in = S_FIN;
            end else begin
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff;
            div_req.divisor  = q_eff;
            state_in         = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               block_in = block_ceil;
               if (rem_zero && !flex_ff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = block_ceil;
                  div_req.divisor  = hop_ff;
                  y_in             = hop_ff;
                  state_in         = S_EUC;
               end else begin
                  left_in  = hop_ff - 1'b1;
                  state_in = S_FIN;
               end
            end
         end
         S_EUC: begin
            if (div_rsp.done) begin
               if (rem_zero) begin
                  left_in  = hop_ff - y_ff;
                  state_in = S_FIN;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = sbsu_pkg::WIDE_W'(y_ff);
                  div_req.divisor  = div_rsp.remainder;
                  y_in             = div_rsp.remainder;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_block_in = block_ff;
               rsp_left_in  = left_ff;
               rsp_ring_in  = block_ff + sbsu_pkg::WIDE_W'(left_ff)
                            + sbsu_pkg::WIDE_W'(hist_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         num_ff       <= sbsu_pkg::HOP_W'(1);
         den_ff       <= sbsu_pkg::HOP_W'(1);
         flex_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_ff       <= num_in;
         den_ff       <= den_in;
         flex_ff      <= flex_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hop_ff       <= hop_in;
      hist_ff      <= hist_in;
      prod_ff      <= prod_in;
      block_ff     <= block_in;
      left_ff      <= left_in;
      y_ff         <= y_in;
      rsp_ring_ff  <= rsp_ring_in;
      rsp_block_ff <= rsp_block_in;
      rsp_left_ff  <= rsp_left_in;
   end

   assign req_chan.ready            = (state_ff == S_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.ring_size        = rsp_ring_ff;
   assign rsp_chan.block_samples    = rsp_block_ff;
   assign rsp_chan.leftover_samples = rsp_left_ff;

   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (div_req.divisor != '0))
      else $error("divider started with zero divisor");

   a_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV || state_ff == S_EUC))
      else $error("divider result outside a divide state");

   a_leftover_below_hop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && hop_ff != '0) |-> (left_ff < hop_ff))
      else $error("leftover not below hop");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the send ring sizing unit. A queue of streams feeds
// a clocked driver, and every accepted item is sized by a local predictor
// (ceiling block, Euclid or flexible leftover, history). A clocked monitor
// checks each result against the oldest prediction. Register settings change
// between drained phases, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [sbsu_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam longint CYCLE_LIMIT  = 3_000_000;
   localparam int     DRAIN_CYCLES = 1000;
   localparam int     HOLD_CYCLES  = 2500;
   localparam int     RANDOM_PHASES = 10;
   localparam int     PHASE_ITEMS   = 54;

   typedef struct packed {
      logic [sbsu_pkg::HOP_W-1:0]  hop_size;
      logic [sbsu_pkg::HIST_W-1:0] history_length;
   } stream_type;

   typedef struct packed {
      logic [sbsu_pkg::WIDE_W-1:0] ring_size;
      logic [sbsu_pkg::WIDE_W-1:0] block_samples;
      logic [sbsu_pkg::LEFT_W-1:0] leftover_samples;
   } ring_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbsu_req_if req_chan ();
   sbsu_rsp_if rsp_chan ();
   sbsu_csr_if csr_chan ();

   send_buffer_size_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   stream_type stream_queue[$];
   ring_type   ring_queue[$];
   stream_type next_stream;
   ring_type   ring_want;

   logic [15:0] numer_reg = 16'd1;
   logic [15:0] denom_reg = 16'd1;
   logic        flex_reg  = 1'b0;

   bit     send_idle = 1'b1;
   bit     recv_idle = 1'b1;
   bit     hold_request = 1'b0;
   bit     hold_started = 1'b0;
   bit     req_fired = 1'b0;
   int     send_gap = 0;
   int     recv_gap = 0;
   int     hold_left = 0;
   int     pushed_count = 0;
   int     stream_count = 0;
   int     ring_count = 0;
   int     error_count = 0;
   int     setting_count = 0;
   longint cycle_count = 0;

   always #5 clock = ~clock;

   function automatic int pick_gap(bit idle_on);
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 200);
   endfunction

   function automatic ring_type size_ring(logic [sbsu_pkg::HOP_W-1:0] hop,
                                          logic [sbsu_pkg::HIST_W-1:0] hist);
      ring_type    r;
      logic [63:0] q, prod, blk, left, a, b, t;
      bit          exact;
      r = '0;
      if (hop == '0) return r;
      q     = (denom_reg == 16'd0) ? 64'd1 : 64'(denom_reg);
      prod  = 64'(numer_reg) * 64'(hop);
      exact = (prod % q) == 64'd0;
      blk   = (prod + q - 64'd1) / q;
      if (exact && !flex_reg) begin
         a = blk;
         b = 64'(hop);
         while (b != 64'd0) begin
            t = a % b;
            a = b;
            b = t;
         end
         left = 64'(hop) - a;
      end else begin
         left = 64'(hop) - 64'd1;
      end
      r.ring_size        = sbsu_pkg::WIDE_W'(blk + left + 64'(hist));
      r.block_samples    = sbsu_pkg::WIDE_W'(blk);
      r.leftover_samples = sbsu_pkg::LEFT_W'(left);
      return r;
   endfunction

   // item driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_chan.valid || req_fired) begin
         if (send_gap > 0) begin
            req_chan.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (stream_queue.size() != 0) begin
            next_stream = stream_queue.pop_front();
            req_chan.hop_size       <= next_stream.hop_size;
            req_chan.history_length <= next_stream.history_length;
            req_chan.valid          <= 1'b1;
            send_gap <= pick_gap(send_idle);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // accepted items are sized here
   always @(posedge clock) begin
      req_fired <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         ring_queue = {ring_queue, size_ring(req_chan.hop_size, req_chan.history_length)};
         stream_count++;
      end
   end

   // result ready with random stalls and one long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_request && !hold_started) begin
         hold_started <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         recv_gap <= pick_gap(recv_idle);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (ring_queue.size() == 0) begin
            $error("result with no item pending: ring_size %0d", rsp_chan.ring_size);
            error_count++;
         end else begin
            ring_want = ring_queue.pop_front();
            ring_count++;
            if (rsp_chan.ring_size !== ring_want.ring_size) begin
               $error("ring_size expected %0d actual %0d",
                      ring_want.ring_size, rsp_chan.ring_size);
               error_count++;
            end
            if (rsp_chan.block_samples !== ring_want.block_samples) begin
               $error("block_samples expected %0d actual %0d",
                      ring_want.block_samples, rsp_chan.block_samples);
               error_count++;
            end
            if (rsp_chan.leftover_samples !== ring_want.leftover_samples) begin
               $error("leftover_samples expected %0d actual %0d",
                      ring_want.leftover_samples, rsp_chan.leftover_samples);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, ring_queue.size());
         $display("[send_buffer_size_unit] ERROR");
         $finish;
      end
   end

   task automatic queue_stream(logic [sbsu_pkg::HOP_W-1:0] hop,
                               logic [sbsu_pkg::HIST_W-1:0] hist);
      stream_type s;
      s.hop_size       = hop;
      s.history_length = hist;
      stream_queue     = {stream_queue, s};
      pushed_count++;
   endtask

   task automatic wait_drained();
      while (stream_count != pushed_count || ring_queue.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [sbsu_pkg::CSR_IDX_W-1:0] index,
                            logic [sbsu_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_chan.reg_index  = index;
      csr_chan.write_data = data;
      csr_chan.valid      = 1'b1;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (index)
         sbsu_pkg::CSR_NUMERATOR:   numer_reg = data;
         sbsu_pkg::CSR_DENOMINATOR: denom_reg = data;
         sbsu_pkg::CSR_FLEXIBLE:    flex_reg  = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic write_settings(logic [15:0] p, logic [15:0] q, logic f);
      csr_write(sbsu_pkg::CSR_NUMERATOR, p);
      csr_write(sbsu_pkg::CSR_DENOMINATOR, q);
      csr_write(sbsu_pkg::CSR_FLEXIBLE, {15'($urandom_range(0, 32767)), f});
      setting_count++;
   endtask

   function automatic logic [sbsu_pkg::HOP_W-1:0] random_hop();
      int unsigned d, r;
      d = (denom_reg == 16'd0) ? 1 : denom_reg;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 8) return 16'hFFFF;
      if (r < 35) return sbsu_pkg::HOP_W'($urandom_range(1, 64));
      if (r < 70) return sbsu_pkg::HOP_W'(d * $urandom_range(1, 65535 / d));
      return sbsu_pkg::HOP_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [sbsu_pkg::HIST_W-1:0] random_history();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25) return '0;
      if (r < 35) return 16'hFFFF;
      return sbsu_pkg::HIST_W'($urandom_range(0, 65535));
   endfunction

   initial begin
      logic [15:0] p, q;
      logic        f;
      int unsigned pick;

      req_chan.valid          = 1'b0;
      req_chan.hop_size       = '0;
      req_chan.history_length = '0;
      rsp_chan.ready          = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.reg_index      = '0;
      csr_chan.write_data     = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: unused stream, smallest and largest hops
      queue_stream(16'd0, 16'hFFFF);
      queue_stream(16'd1, 16'd0);
      queue_stream(16'hFFFF, 16'hFFFF);
      queue_stream(16'd12, 16'd3);
      queue_stream(16'd0, 16'd0);
      wait_drained();

      // widest block
      write_settings(16'hFFFF, 16'd1, 1'b0);
      queue_stream(16'hFFFF, 16'hFFFF);
      queue_stream(16'd3, 16'd5);
      wait_drained();

      // exact division but flexible blocks
      write_settings(16'd3, 16'd4, 1'b1);
      queue_stream(16'd8, 16'd2);
      queue_stream(16'd6, 16'd1);
      wait_drained();

      // zero numerator and zero denominator
      write_settings(16'd0, 16'd0, 1'b0);
      queue_stream(16'd5, 16'd7);
      queue_stream(16'hFFFF, 16'd0);
      wait_drained();

      // spare register index is ignored
      csr_write(CSR_SPARE, 16'hFFFF);
      write_settings(16'd7, 16'hFFFF, 1'b0);
      queue_stream(16'hFFFF, 16'd100);
      queue_stream(16'd100, 16'hFFFF);
      wait_drained();

      // gcd path with nontrivial divisors
      write_settings(16'd12, 16'd8, 1'b0);
      queue_stream(16'd6, 16'd0);
      queue_stream(16'd4, 16'd9);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0) begin
            p = 16'd1;
            q = 16'hFFFF;
            f = 1'b0;
         end else if (ph == 1) begin
            p = 16'hFFFF;
            q = 16'hFFFF;
            f = 1'b1;
         end else begin
            pick = $urandom_range(0, 11);
            p = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : (pick == 2) ? 16'd1 :
                16'($urandom_range(1, 65535));
            pick = $urandom_range(0, 9);
            q = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : (pick < 4) ? p :
                (pick < 7) ? 16'($urandom_range(1, 16)) : 16'($urandom_range(1, 65535));
            f = ($urandom_range(0, 2) == 0);
         end
         write_settings(p, q, f);
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++) queue_stream(random_hop(), random_history());
         wait_drained();

         if (ph == 4) begin
            // result side held off while items keep coming
            write_settings(16'd5, 16'd3, 1'b0);
            send_idle = 1'b0;
            recv_idle = 1'b0;
            hold_request = 1'b1;
            for (int n = 0; n < 20; n++) begin
               queue_stream(sbsu_pkg::HOP_W'($urandom_range(1, 16) * 3), random_history());
            end
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d items over %0d register settings, %0d results checked",
               stream_count, setting_count, ring_count);
      $display("including zero hops and ratios, exact and flexible leftovers, a long stall");
      if (error_count == 0) begin
         $display("[send_buffer_size_unit] OK");
      end else begin
         $display("[send_buffer_size_unit] ERROR");
      end
      $finish;
   end

endmodule
